// File: rtl/core/hppc_pkg.sv
// Shared widths, codes and types for the heater power PI controller.
`timescale 1ns / 1ps
`default_nettype none

package hppc_pkg;

  // Field widths of the input beat, result beat and registers
  localparam int ACT_W      = 2;
  localparam int SETV_W     = 16;
  localparam int TEMP_W     = 12;
  localparam int METER_W    = 15;
  localparam int TPWR_W     = 14;
  localparam int PCT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 15;
  localparam int WATT_W     = 14;
  localparam int INTEG_W    = 16;
  localparam int ERR_W      = TEMP_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Arithmetic constants
  localparam int PCT_FULL       = 100;
  localparam int METER_STEP     = 5;
  localparam int METER_TOL_MUL  = 20;
  localparam int MTOL_W         = METER_W + 5;
  localparam int PI_FRAC        = 12;
  localparam int PROD_W         = GAIN_W + 1 + INTEG_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int DIV_QBITS      = PCT_W;
  localparam int DIV_QCNT_W     = $clog2(DIV_QBITS);
  localparam int DIVR_W         = WATT_W + DIV_QBITS;

  // Reset values of registers
  localparam int DEF_MAX_WATTS  = 3000;

  // Default timing parameters
  localparam int DEF_WINDOW_TICKS = 100;
  localparam int DEF_LOOP_TICKS   = 1000;
  localparam int DEF_METER_TICKS  = 2000;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_PCT  = 2'd1,
    ACT_SET_WATT = 2'd2
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MANUAL = 2'd0,
    MODE_PI     = 2'd1,
    MODE_METER  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_GAIN_P    = 3'd1,
    CFG_GAIN_I    = 3'd2,
    CFG_ILIM      = 3'd3,
    CFG_OUT_MIN   = 3'd4,
    CFG_OUT_MAX   = 3'd5,
    CFG_TARGET    = 3'd6,
    CFG_MAX_WATTS = 3'd7
  } cfg_idx_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LATCH    = 4'd1,
    OP_SET_PCT  = 4'd2,
    OP_TICK     = 4'd3,
    OP_DIV_INIT = 4'd4,
    OP_DIV_STEP = 4'd5,
    OP_DIV_END  = 4'd6,
    OP_MUL_P    = 4'd7,
    OP_MUL_I    = 4'd8,
    OP_SUM      = 4'd9,
    OP_PI_END   = 4'd10,
    OP_EMIT     = 4'd11
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             pi_go;
    logic             out_free;
  } dp_status_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [SETV_W-1:0]        set_value;
    logic                     run_enable;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sensor_ok;
    logic [METER_W-1:0]       meter_power_w;
    logic [TPWR_W-1:0]        target_power_w;
  } in_item_t;

  typedef struct packed {
    logic             heater_on;
    logic [PCT_W-1:0] power_percent;
    logic             loop_updated;
    logic             sensor_fault;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/hppc_if.sv
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface hppc_in_if import hppc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [SETV_W-1:0]        set_value;
  logic                     run_enable;
  logic signed [TEMP_W-1:0] temperature;
  logic                     sensor_ok;
  logic [METER_W-1:0]       meter_power_w;
  logic [TPWR_W-1:0]        target_power_w;

  modport source (
    output valid, action, set_value, run_enable, temperature, sensor_ok,
           meter_power_w, target_power_w,
    input  ready
  );

  modport sink (
    input  valid, action, set_value, run_enable, temperature, sensor_ok,
           meter_power_w, target_power_w,
    output ready
  );
endinterface

interface hppc_out_if import hppc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             heater_on;
  logic [PCT_W-1:0] power_percent;
  logic             loop_updated;
  logic             sensor_fault;

  modport source (
    output valid, heater_on, power_percent, loop_updated, sensor_fault,
    input  ready
  );

  modport sink (
    input  valid, heater_on, power_percent, loop_updated, sensor_fault,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/hppc_ctrl.sv
// Sequencer that walks each beat through the datapath operations.
`timescale 1ns / 1ps
`default_nettype none

module hppc_ctrl import hppc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  dp_status_t status,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_DIV     = 9'b000000100,
    S_DIV_END = 9'b000001000,
    S_MUL_P   = 9'b000010000,
    S_MUL_I   = 9'b000100000,
    S_SUM     = 9'b001000000,
    S_PI_END  = 9'b010000000,
    S_EMIT    = 9'b100000000
  } ctrl_state_t;

  ctrl_state_t           state_r, state_nxt;
  logic [DIV_QCNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // Next state and operation select
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd.op      = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.action)
          ACT_TICK: begin
            cmd.op    = OP_TICK;
            state_nxt = status.pi_go ? S_MUL_P : S_EMIT;
          end
          ACT_SET_PCT: begin
            cmd.op    = OP_SET_PCT;
            state_nxt = S_EMIT;
          end
          ACT_SET_WATT: begin
            cmd.op      = OP_DIV_INIT;
            div_cnt_nxt = '0;
            state_nxt   = S_DIV;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_DIV: begin
        // one quotient bit per cycle
        cmd.op = OP_DIV_STEP;
        if (div_cnt_r == DIV_QCNT_W'(DIV_QBITS - 1)) begin
          state_nxt = S_DIV_END;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_QCNT_W'(1);
        end
      end
      S_DIV_END: begin
        cmd.op    = OP_DIV_END;
        state_nxt = S_EMIT;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.op    = OP_MUL_I;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_PI_END;
      end
      S_PI_END: begin
        cmd.op    = OP_PI_END;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/hppc_dp.sv
// Datapath: registers, timers, shared multiplier, serial divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module hppc_dp import hppc_pkg::*; #(
  parameter int WINDOW_TICKS = DEF_WINDOW_TICKS,
  parameter int LOOP_TICKS   = DEF_LOOP_TICKS,
  parameter int METER_TICKS  = DEF_METER_TICKS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  cfg_wr_t    cfg,
  input  dp_cmd_t    cmd,
  input  logic       out_ready,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int PH_W = (WINDOW_TICKS > 1) ? $clog2(WINDOW_TICKS) : 1;
  localparam int LT_W = $clog2(LOOP_TICKS + 1);
  localparam int MT_W = $clog2(METER_TICKS + 1);
  localparam int ON_W = $clog2(WINDOW_TICKS * PCT_FULL + 1);

  // Configuration registers
  logic [MODE_W-1:0]        mode_r;
  logic [GAIN_W-1:0]        gain_p_r, gain_i_r;
  logic [ILIM_W-1:0]        ilim_r;
  logic [PCT_W-1:0]         out_min_r, out_max_r;
  logic signed [TEMP_W-1:0] target_r;
  logic [WATT_W-1:0]        max_w_r;
  logic                     integ_clear;

  // Working state
  in_item_t                  item_r;
  logic [PCT_W-1:0]          power_r, power_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic [LT_W-1:0]           loop_timer_r, loop_timer_nxt;
  logic [MT_W-1:0]           meter_timer_r, meter_timer_nxt;
  logic [PH_W-1:0]           phase_r, phase_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DIVR_W-1:0]         rem_r, rem_nxt, divs_r, divs_nxt;
  logic [DIV_QBITS-1:0]      q_r, q_nxt;
  logic                      upd_r, upd_nxt, fault_r, fault_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  // Combinational helpers
  logic [LT_W-1:0]             lt_inc;
  logic [MT_W-1:0]             mt_inc;
  logic                        pi_due, meter_due;
  logic signed [ERR_W-1:0]     err_c;
  logic signed [INTEG_W:0]     integ_sum, lim_pos, lim_neg, integ_clamp;
  logic signed [METER_W:0]     meter_diff;
  logic [METER_W-1:0]          meter_abs;
  logic                        meter_big, meter_low;
  logic [PCT_W-1:0]            pwr_up, pwr_dn;
  logic signed [GAIN_W:0]      mul_a;
  logic signed [INTEG_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod_c;
  logic signed [SUM_W-1:0]     pi_lo, pi_hi;
  logic [PCT_W-1:0]            pi_raw, pi_pct;
  logic [WATT_W-1:0]           watt_c;
  logic                        div_ge;
  logic [PCT_W-1:0]            set_pct;
  logic [ON_W-1:0]             on_prod, ph_prod;

  // Configuration writes, with the integral clear on gain, output limit, setpoint and PI mode writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_MANUAL;
      gain_p_r  <= '0;
      gain_i_r  <= '0;
      ilim_r    <= '0;
      out_min_r <= '0;
      out_max_r <= PCT_W'(PCT_FULL);
      target_r  <= '0;
      max_w_r   <= WATT_W'(DEF_MAX_WATTS);
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_MODE:      mode_r    <= cfg.data[MODE_W-1:0];
        CFG_GAIN_P:    gain_p_r  <= cfg.data[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i_r  <= cfg.data[GAIN_W-1:0];
        CFG_ILIM:      ilim_r    <= cfg.data[ILIM_W-1:0];
        CFG_OUT_MIN:   out_min_r <= cfg.data[PCT_W-1:0];
        CFG_OUT_MAX:   out_max_r <= cfg.data[PCT_W-1:0];
        CFG_TARGET:    target_r  <= $signed(cfg.data[TEMP_W-1:0]);
        CFG_MAX_WATTS: max_w_r   <= cfg.data[WATT_W-1:0];
        default: ;
      endcase
    end
  end

  assign integ_clear = cfg.we &&
    ((cfg.index == CFG_GAIN_P) || (cfg.index == CFG_GAIN_I) ||
     (cfg.index == CFG_OUT_MIN) || (cfg.index == CFG_OUT_MAX) ||
     (cfg.index == CFG_TARGET) ||
     ((cfg.index == CFG_MODE) && (cfg.data[MODE_W-1:0] == MODE_PI)));

  // Timer advance and due checks for the latched beat
  assign lt_inc = (loop_timer_r < LT_W'(LOOP_TICKS)) ? loop_timer_r + LT_W'(1) : loop_timer_r;
  assign mt_inc = (meter_timer_r < MT_W'(METER_TICKS)) ? meter_timer_r + MT_W'(1)
                                                       : meter_timer_r;
  assign pi_due    = item_r.run_enable && (mode_r == MODE_PI) && (lt_inc == LT_W'(LOOP_TICKS));
  assign meter_due = item_r.run_enable && (mode_r == MODE_METER) &&
                     (mt_inc == MT_W'(METER_TICKS));

  // Error and clamped integral
  assign err_c     = $signed({target_r[TEMP_W-1], target_r}) -
                     $signed({item_r.temperature[TEMP_W-1], item_r.temperature});
  assign integ_sum = $signed({integ_r[INTEG_W-1], integ_r}) +
                     $signed({{(INTEG_W + 1 - ERR_W){err_c[ERR_W-1]}}, err_c});
  assign lim_pos   = $signed({{(INTEG_W + 1 - ILIM_W){1'b0}}, ilim_r});
  assign lim_neg   = -lim_pos;

  always_comb begin
    priority if (integ_sum < lim_neg) begin
      integ_clamp = lim_neg;
    end else if (integ_sum > lim_pos) begin
      integ_clamp = lim_pos;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  // Meter comparison and five-percent steps
  assign meter_diff = $signed({1'b0, item_r.meter_power_w}) -
                      $signed({{(METER_W + 1 - TPWR_W){1'b0}}, item_r.target_power_w});
  assign meter_abs  = meter_diff[METER_W] ? METER_W'(-meter_diff) : meter_diff[METER_W-1:0];
  assign meter_big  = (MTOL_W'(meter_abs) * MTOL_W'(METER_TOL_MUL)) >
                      MTOL_W'(item_r.target_power_w);
  assign meter_low  = meter_diff[METER_W];
  assign pwr_up = (power_r > PCT_W'(PCT_FULL - METER_STEP)) ? PCT_W'(PCT_FULL)
                                                            : power_r + PCT_W'(METER_STEP);
  assign pwr_dn = (power_r < PCT_W'(METER_STEP)) ? '0 : power_r - PCT_W'(METER_STEP);

  // Shared multiplier: proportional term first, integral term second
  assign mul_a  = $signed({1'b0, (cmd.op == OP_MUL_P) ? gain_p_r : gain_i_r});
  assign mul_b  = (cmd.op == OP_MUL_P) ?
                  $signed({{(INTEG_W - ERR_W){err_r[ERR_W-1]}}, err_r}) : integ_r;
  assign prod_c = mul_a * mul_b;

  // Output clamp of the PI sum (scaled by 4096)
  assign pi_lo = $signed({{(SUM_W - PCT_W - PI_FRAC){1'b0}}, out_min_r, {PI_FRAC{1'b0}}});
  assign pi_hi = $signed({{(SUM_W - PCT_W - PI_FRAC){1'b0}}, out_max_r, {PI_FRAC{1'b0}}});

  always_comb begin
    priority if (sum_r < pi_lo) begin
      pi_raw = out_min_r;
    end else if (sum_r > pi_hi) begin
      pi_raw = out_max_r;
    end else begin
      pi_raw = sum_r[PI_FRAC+PCT_W-1:PI_FRAC];
    end
  end

  assign pi_pct = (pi_raw > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pi_raw;

  // Watt request: clamp, then restoring divide one bit a cycle
  assign watt_c = (item_r.set_value > SETV_W'(max_w_r)) ? max_w_r
                                                        : item_r.set_value[WATT_W-1:0];
  assign div_ge = (rem_r >= divs_r);

  assign set_pct = (item_r.set_value > SETV_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                          : item_r.set_value[PCT_W-1:0];

  // Relay: on while phase < WINDOW*pct/100, compared without a divide
  assign on_prod = ON_W'(WINDOW_TICKS) * ON_W'(power_r);
  assign ph_prod = ON_W'(PCT_FULL) * (ON_W'(phase_r) + ON_W'(1));

  // Next values per operation
  always_comb begin
    power_nxt       = power_r;
    integ_nxt       = integ_r;
    loop_timer_nxt  = loop_timer_r;
    meter_timer_nxt = meter_timer_r;
    phase_nxt       = phase_r;
    err_nxt         = err_r;
    prod_nxt        = prod_r;
    sum_nxt         = sum_r;
    rem_nxt         = rem_r;
    divs_nxt        = divs_r;
    q_nxt           = q_r;
    upd_nxt         = upd_r;
    fault_nxt       = fault_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_item_nxt    = out_item_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_LATCH: begin
        upd_nxt   = 1'b0;
        fault_nxt = 1'b0;
      end
      OP_SET_PCT: begin
        power_nxt = set_pct;
      end
      OP_TICK: begin
        loop_timer_nxt  = pi_due ? '0 : lt_inc;
        meter_timer_nxt = (!pi_due && meter_due) ? '0 : mt_inc;
        if (pi_due) begin
          if (item_r.sensor_ok) begin
            integ_nxt = integ_clamp[INTEG_W-1:0];
            err_nxt   = err_c;
            upd_nxt   = 1'b1;
          end else begin
            fault_nxt = 1'b1;
          end
        end else if (meter_due) begin
          upd_nxt = 1'b1;
          if (meter_big) begin
            power_nxt = meter_low ? pwr_up : pwr_dn;
          end
        end
      end
      OP_DIV_INIT: begin
        rem_nxt  = DIVR_W'(watt_c) * DIVR_W'(PCT_FULL);
        divs_nxt = DIVR_W'({max_w_r, {(DIV_QBITS - 1){1'b0}}});
        q_nxt    = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt  = div_ge ? rem_r - divs_r : rem_r;
        q_nxt    = {q_r[DIV_QBITS-2:0], div_ge};
        divs_nxt = divs_r >> 1;
      end
      OP_DIV_END: begin
        if (max_w_r == '0) begin
          power_nxt = '0;
        end else begin
          power_nxt = (q_r > DIV_QBITS'(PCT_FULL)) ? PCT_W'(PCT_FULL) : q_r;
        end
      end
      OP_MUL_P: begin
        prod_nxt = prod_c;
      end
      OP_MUL_I: begin
        sum_nxt  = SUM_W'(prod_r);
        prod_nxt = prod_c;
      end
      OP_SUM: begin
        sum_nxt = sum_r + SUM_W'(prod_r);
      end
      OP_PI_END: begin
        power_nxt = pi_pct;
      end
      OP_EMIT: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.heater_on     = (on_prod >= ph_prod);
        out_item_nxt.power_percent = power_r;
        out_item_nxt.loop_updated  = upd_r;
        out_item_nxt.sensor_fault  = fault_r;
        if (item_r.action == ACT_TICK) begin
          phase_nxt = (phase_r == PH_W'(WINDOW_TICKS - 1)) ? '0 : phase_r + PH_W'(1);
        end
      end
      default: ;
    endcase
    if (integ_clear) begin
      integ_nxt = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r       <= '0;
      integ_r       <= '0;
      loop_timer_r  <= '0;
      meter_timer_r <= '0;
      phase_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      power_r       <= power_nxt;
      integ_r       <= integ_nxt;
      loop_timer_r  <= loop_timer_nxt;
      meter_timer_r <= meter_timer_nxt;
      phase_r       <= phase_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      item_r <= in_item;
    end
    err_r      <= err_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    divs_r     <= divs_nxt;
    q_r        <= q_nxt;
    upd_r      <= upd_nxt;
    fault_r    <= fault_nxt;
    out_item_r <= out_item_nxt;
  end

  assign status.action   = item_r.action;
  assign status.pi_go    = pi_due && item_r.sensor_ok;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

endmodule

`default_nettype wire

// File: rtl/core/heater_power_pi_controller_unit.sv
// Top level of the heater power PI controller: sequencer, datapath and channels.
//
//  channel  dir  handshake       beat contents
//  in_bus   in   valid/ready     action, set_value, run_enable, temperature, sensor_ok,
//                                meter_power_w, target_power_w
//  out_bus  out  valid/ready     heater_on, power_percent, loop_updated, sensor_fault
//  cfg_*    in   cfg_we only     cfg_index selects register, cfg_data is the value
//
// One beat in flight at a time; in_bus.ready returns once a tick or percent request has
// passed decode and emit, once a tick that runs the PI step has also used the shared
// multiplier twice, then sum and clamp, and once a watt request has run the restoring divider.
// The result sits in an output register, so a new beat is taken while it waits.
// A stalled result holds the sequencer in its emit step until out_bus.ready.
// rst_n is synchronous: registers return to their reset values, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module heater_power_pi_controller_unit import hppc_pkg::*; #(
  parameter int WINDOW_TICKS = DEF_WINDOW_TICKS,
  parameter int LOOP_TICKS   = DEF_LOOP_TICKS,
  parameter int METER_TICKS  = DEF_METER_TICKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hppc_in_if.sink               in_bus,
  hppc_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  in_item_t   in_item;
  out_item_t  out_item;
  cfg_wr_t    cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_accept;
  logic       out_valid;

  // Pack the input beat and the register write
  assign in_item.action         = in_bus.action;
  assign in_item.set_value      = in_bus.set_value;
  assign in_item.run_enable     = in_bus.run_enable;
  assign in_item.temperature    = in_bus.temperature;
  assign in_item.sensor_ok      = in_bus.sensor_ok;
  assign in_item.meter_power_w  = in_bus.meter_power_w;
  assign in_item.target_power_w = in_bus.target_power_w;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_accept    = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;

  hppc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  hppc_dp #(
    .WINDOW_TICKS (WINDOW_TICKS),
    .LOOP_TICKS   (LOOP_TICKS),
    .METER_TICKS  (METER_TICKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg),
    .cmd       (cmd),
    .out_ready (out_bus.ready),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Drive the result channel
  assign out_bus.valid         = out_valid;
  assign out_bus.heater_on     = out_item.heater_on;
  assign out_bus.power_percent = out_item.power_percent;
  assign out_bus.loop_updated  = out_item.loop_updated;
  assign out_bus.sensor_fault  = out_item.sensor_fault;

endmodule

`default_nettype wire

// File: rtl/core/hppc_checker.sv
// Port-level assertions for the heater power PI controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hppc_checker import hppc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             heater_on,
  input logic [PCT_W-1:0] power_percent,
  input logic             loop_updated,
  input logic             sensor_fault
);

  // Percent never leaves its range
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (power_percent <= PCT_W'(PCT_FULL)))
    else $error("power_percent above full scale");

  // A tick is an update, a fault or neither, never both
  a_upd_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(loop_updated && sensor_fault))
    else $error("loop_updated and sensor_fault both set");

  // Zero percent keeps the relay off
  a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (power_percent == '0)) |-> !heater_on)
    else $error("relay on at zero percent");

  // One beat at a time: ready drops after an accepted beat
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(power_percent) && $stable(heater_on)))
    else $error("stalled result changed");

endmodule

bind heater_power_pi_controller_unit hppc_checker u_hppc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .heater_on     (out_bus.heater_on),
  .power_percent (out_bus.power_percent),
  .loop_updated  (out_bus.loop_updated),
  .sensor_fault  (out_bus.sensor_fault)
);

`default_nettype wire

// File: verif/tb_heater_power_pi_controller_unit.sv
// Self-checking testbench for the heater power PI controller: directed table, then random segments.
`timescale 1ns / 1ps

module tb_heater_power_pi_controller_unit;
  import hppc_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int STALL_LIMIT = 4000;
  localparam int SEGMENTS    = 30;
  localparam int FRAC_ONE    = 1 << PI_FRAC;

  typedef struct {
    bit                    is_reg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    int                    reps;
    in_item_t              beat;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hppc_in_if  in_bus ();
  hppc_out_if out_bus ();

  heater_power_pi_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies kept by the predictor
  logic [MODE_W-1:0]        mode_r;
  logic [GAIN_W-1:0]        kp_r;
  logic [GAIN_W-1:0]        ki_r;
  logic [ILIM_W-1:0]        ilim_r;
  logic [PCT_W-1:0]         omin_r;
  logic [PCT_W-1:0]         omax_r;
  logic signed [TEMP_W-1:0] target_r;
  logic [WATT_W-1:0]        max_watts_r;

  // Regulator state kept by the predictor
  int power_pct;
  int integ_acc;
  int loop_cnt;
  int meter_cnt;
  int window_pos;

  out_item_t pending_results[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        send_idle;
  int        recv_idle;

  always #10 clk = ~clk;

  function automatic int clamp_pct(longint v);
    if (v < 0) return 0;
    if (v > PCT_FULL) return PCT_FULL;
    return int'(v);
  endfunction

  // Mirror a register write, including the integral clears it causes
  function automatic void write_model_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_MODE: begin
        mode_r = d[MODE_W-1:0];
        if (mode_r == MODE_PI) integ_acc = 0;
      end
      CFG_GAIN_P: begin
        kp_r = d[GAIN_W-1:0];
        integ_acc = 0;
      end
      CFG_GAIN_I: begin
        ki_r = d[GAIN_W-1:0];
        integ_acc = 0;
      end
      CFG_ILIM: ilim_r = d[ILIM_W-1:0];
      CFG_OUT_MIN: begin
        omin_r = d[PCT_W-1:0];
        integ_acc = 0;
      end
      CFG_OUT_MAX: begin
        omax_r = d[PCT_W-1:0];
        integ_acc = 0;
      end
      CFG_TARGET: begin
        target_r = d[TEMP_W-1:0];
        integ_acc = 0;
      end
      CFG_MAX_WATTS: max_watts_r = d[WATT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the regulator by one beat and return the result it must produce
  function automatic out_item_t next_heater_result(in_item_t b);
    out_item_t r;
    int        phase_now;
    int        err;
    int        acc;
    int        watts;
    int        meas;
    int        goal;
    int        diff;
    longint    s;
    longint    pct;
    r = '0;
    phase_now = window_pos;
    case (b.action)
      ACT_SET_PCT: power_pct = clamp_pct(longint'(b.set_value));
      ACT_SET_WATT: begin
        if (max_watts_r == 0) begin
          power_pct = 0;
        end else begin
          watts = int'(b.set_value);
          if (watts > int'(max_watts_r)) watts = int'(max_watts_r);
          power_pct = clamp_pct(longint'(watts * PCT_FULL / int'(max_watts_r)));
        end
      end
      ACT_TICK: begin
        if (loop_cnt < DEF_LOOP_TICKS) loop_cnt++;
        if (meter_cnt < DEF_METER_TICKS) meter_cnt++;
        if (b.run_enable && mode_r == MODE_PI && loop_cnt >= DEF_LOOP_TICKS) begin
          if (b.sensor_ok) begin
            // PI step: clamp the integral, then clamp the scaled sum to the limits
            err = int'(target_r) - int'($signed(b.temperature));
            acc = integ_acc + err;
            if (acc < -int'(ilim_r)) acc = -int'(ilim_r);
            else if (acc > int'(ilim_r)) acc = int'(ilim_r);
            integ_acc = acc;
            s = longint'(kp_r) * err + longint'(ki_r) * acc;
            if (s < longint'(omin_r) * FRAC_ONE) pct = omin_r;
            else if (s > longint'(omax_r) * FRAC_ONE) pct = omax_r;
            else pct = s / FRAC_ONE;
            power_pct = clamp_pct(pct);
            r.loop_updated = 1'b1;
          end else begin
            r.sensor_fault = 1'b1;
          end
          loop_cnt = 0;
        end else if (b.run_enable && mode_r == MODE_METER && meter_cnt >= DEF_METER_TICKS) begin
          // Meter step: move toward the target only outside the tolerance band
          meas = int'(b.meter_power_w);
          goal = int'(b.target_power_w);
          diff = meas > goal ? meas - goal : goal - meas;
          if (diff * METER_TOL_MUL > goal)
            power_pct = clamp_pct(power_pct + (meas < goal ? METER_STEP : -METER_STEP));
          r.loop_updated = 1'b1;
          meter_cnt = 0;
        end
        window_pos++;
        if (window_pos >= DEF_WINDOW_TICKS) window_pos = 0;
      end
      default: ;
    endcase
    r.heater_on = phase_now < DEF_WINDOW_TICKS * power_pct / PCT_FULL;
    r.power_percent = power_pct[PCT_W-1:0];
    return r;
  endfunction

  function automatic out_item_t steady(bit on, int pct);
    out_item_t r;
    r = '0;
    r.heater_on = on;
    r.power_percent = pct[PCT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t beat(logic [ACT_W-1:0] act, int setv, bit run, int temp,
                                     bit ok, int meas, int goal, int reps = 1,
                                     bit typed = 1'b0, out_item_t want = '0);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.idx = CFG_MODE;
    r.data = '0;
    r.reps = reps;
    r.beat.action = act;
    r.beat.set_value = setv[SETV_W-1:0];
    r.beat.run_enable = run;
    r.beat.temperature = temp[TEMP_W-1:0];
    r.beat.sensor_ok = ok;
    r.beat.meter_power_w = meas[METER_W-1:0];
    r.beat.target_power_w = goal[TPWR_W-1:0];
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(cfg_idx_t idx, int d);
    plan_row_t r;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = d[CFG_DATA_W-1:0];
    r.reps = 0;
    r.beat = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Write one register: hold the enable for a single edge, then drop it
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    write_model_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one beat after an optional idle gap and record its expected result once taken
  task automatic send_beat(in_item_t b, bit typed, out_item_t want);
    out_item_t predicted;
    if ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_bus.valid          <= 1'b1;
    in_bus.action         <= b.action;
    in_bus.set_value      <= b.set_value;
    in_bus.run_enable     <= b.run_enable;
    in_bus.temperature    <= b.temperature;
    in_bus.sensor_ok      <= b.sensor_ok;
    in_bus.meter_power_w  <= b.meter_power_w;
    in_bus.target_power_w <= b.target_power_w;
    do @(posedge clk); while (!in_bus.ready);
    predicted = next_heater_result(b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every result is back and the block takes beats again
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || !in_bus.ready);
  endtask

  // Result-side stalls
  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= $urandom_range(99) >= recv_idle;
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    string     diffs;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.heater_on     = out_bus.heater_on;
      got.power_percent = out_bus.power_percent;
      got.loop_updated  = out_bus.loop_updated;
      got.sensor_fault  = out_bus.sensor_fault;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        diffs = "";
        if (got.heater_on !== want.heater_on)
          diffs = {diffs, $sformatf(" heater_on %0b/%0b", got.heater_on, want.heater_on)};
        if (got.power_percent !== want.power_percent)
          diffs = {diffs, $sformatf(" power_percent %0d/%0d",
                                    got.power_percent, want.power_percent)};
        if (got.loop_updated !== want.loop_updated)
          diffs = {diffs, $sformatf(" loop_updated %0b/%0b",
                                    got.loop_updated, want.loop_updated)};
        if (got.sensor_fault !== want.sensor_fault)
          diffs = {diffs, $sformatf(" sensor_fault %0b/%0b",
                                    got.sensor_fault, want.sensor_fault)};
        if (diffs != "") report_mismatch({"result differs (got/expected):", diffs});
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_item_t b;
    int       roll;
    int       t;
    int       lo;
    int       hi;
    int       goal;
    int       spread;
    int       seg_items;

    // Known levels from time zero
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_bus.valid          = 1'b0;
    in_bus.action         = ACT_TICK;
    in_bus.set_value      = '0;
    in_bus.run_enable     = 1'b0;
    in_bus.temperature    = '0;
    in_bus.sensor_ok      = 1'b0;
    in_bus.meter_power_w  = '0;
    in_bus.target_power_w = '0;
    out_bus.ready         = 1'b0;

    // Predictor starts from the reset state
    mode_r      = MODE_MANUAL;
    kp_r        = '0;
    ki_r        = '0;
    ilim_r      = '0;
    omin_r      = '0;
    omax_r      = PCT_FULL;
    target_r    = '0;
    max_watts_r = DEF_MAX_WATTS;
    power_pct   = 0;
    integ_acc   = 0;
    loop_cnt    = 0;
    meter_cnt   = 0;
    window_pos  = 0;

    send_idle = 8;
    recv_idle = 65;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests, unused action and zero full scale, checked against typed values
    plan.push_back(beat(ACT_TICK, 0, 1, 0, 1, 0, 0, 1, 1, steady(0, 0)));
    plan.push_back(beat(ACT_SET_PCT, 100, 1, 0, 1, 0, 0, 1, 1, steady(1, 100)));
    plan.push_back(beat(ACT_SET_PCT, 65535, 0, 0, 0, 0, 0, 1, 1, steady(1, 100)));
    plan.push_back(beat(ACT_SET_PCT, 0, 1, 0, 1, 0, 0, 1, 1, steady(0, 0)));
    plan.push_back(beat(ACT_SET_WATT, 3000, 1, 0, 1, 0, 0, 1, 1, steady(1, 100)));
    plan.push_back(beat(ACT_SET_WATT, 65535, 0, 0, 1, 0, 0, 1, 1, steady(1, 100)));
    plan.push_back(beat(ACT_SET_WATT, 1500, 1, 0, 1, 0, 0, 1, 1, steady(1, 50)));
    plan.push_back(beat(ACT_SET_WATT, 29, 1, 0, 1, 0, 0, 1, 1, steady(0, 0)));
    plan.push_back(beat(ACT_UNUSED, 77, 1, 0, 1, 0, 0, 1, 1, steady(0, 0)));
    plan.push_back(beat(ACT_SET_PCT, 40, 0, 0, 1, 0, 0, 1, 1, steady(1, 40)));
    plan.push_back(reg_row(CFG_MAX_WATTS, 0));
    plan.push_back(beat(ACT_SET_WATT, 12345, 1, 0, 1, 0, 0, 1, 1, steady(0, 0)));
    plan.push_back(reg_row(CFG_MAX_WATTS, 16000));
    plan.push_back(beat(ACT_SET_WATT, 16000, 1, 0, 1, 0, 0, 1, 1, steady(1, 100)));
    // Spare mode acts as manual while both timers saturate
    plan.push_back(reg_row(CFG_MODE, MODE_SPARE));
    plan.push_back(beat(ACT_TICK, 0, 1, 0, 1, 0, 0, 2100));
    // PI: a due step with the sensor out still restarts the loop timer
    plan.push_back(reg_row(CFG_MODE, MODE_PI));
    plan.push_back(reg_row(CFG_GAIN_P, 256));
    plan.push_back(reg_row(CFG_GAIN_I, 64));
    plan.push_back(reg_row(CFG_ILIM, 32767));
    plan.push_back(reg_row(CFG_OUT_MIN, 0));
    plan.push_back(reg_row(CFG_OUT_MAX, 100));
    plan.push_back(reg_row(CFG_TARGET, 2000));
    plan.push_back(beat(ACT_TICK, 0, 1, -880, 0, 0, 0));
    plan.push_back(beat(ACT_TICK, 0, 1, -880, 1, 0, 0));
    plan.push_back(beat(ACT_TICK, 0, 0, -880, 1, 0, 0, 1000));
    plan.push_back(beat(ACT_TICK, 0, 1, -880, 1, 0, 0));
    // Crossed output limits: the lower limit wins
    plan.push_back(reg_row(CFG_OUT_MIN, 90));
    plan.push_back(reg_row(CFG_OUT_MAX, 10));
    plan.push_back(beat(ACT_TICK, 0, 0, 2000, 1, 0, 0, 1000));
    plan.push_back(beat(ACT_TICK, 0, 1, 2000, 1, 0, 0));
    // Largest gains with no integral room and a negative error
    plan.push_back(reg_row(CFG_GAIN_P, 65535));
    plan.push_back(reg_row(CFG_GAIN_I, 65535));
    plan.push_back(reg_row(CFG_ILIM, 0));
    plan.push_back(reg_row(CFG_OUT_MIN, 0));
    plan.push_back(reg_row(CFG_OUT_MAX, 100));
    plan.push_back(reg_row(CFG_TARGET, -880));
    plan.push_back(beat(ACT_TICK, 0, 0, 2000, 1, 0, 0, 1000));
    plan.push_back(beat(ACT_TICK, 0, 1, 2000, 1, 0, 0));
    // Meter stepping down, up, and inside the tolerance band
    plan.push_back(beat(ACT_SET_PCT, 50, 1, 0, 1, 0, 0));
    plan.push_back(reg_row(CFG_MODE, MODE_METER));
    plan.push_back(beat(ACT_TICK, 0, 1, 0, 1, 25000, 0));
    plan.push_back(beat(ACT_TICK, 0, 1, 0, 1, 0, 16000));
    plan.push_back(beat(ACT_TICK, 0, 0, 0, 1, 0, 16000, 2000));
    plan.push_back(beat(ACT_TICK, 0, 1, 0, 1, 0, 16000));
    plan.push_back(beat(ACT_TICK, 0, 0, 0, 1, 16000, 16000, 2000));
    plan.push_back(beat(ACT_TICK, 0, 1, 0, 1, 16000, 16000));
    plan.push_back(reg_row(CFG_MODE, MODE_MANUAL));

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        repeat (plan[i].reps) send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // Random segments: fresh settings while idle, then a long run of mostly ticks
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        send_idle = 65;
        recv_idle = 8;
      end else if (seg == 2 * SEGMENTS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      drain();

      roll = $urandom_range(99);
      write_reg(CFG_MODE, roll < 45 ? MODE_PI : roll < 75 ? MODE_METER :
                          roll < 90 ? MODE_MANUAL : MODE_SPARE);
      if ($urandom_range(3) != 0) begin
        roll = $urandom_range(9);
        write_reg(CFG_GAIN_P, roll == 0 ? 16'd0 : roll == 1 ? 16'hFFFF :
                              roll < 6 ? 16'($urandom_range(0, 2048)) :
                              16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(3) != 0) begin
        roll = $urandom_range(9);
        write_reg(CFG_GAIN_I, roll == 0 ? 16'd0 : roll == 1 ? 16'hFFFF :
                              roll < 6 ? 16'($urandom_range(0, 512)) :
                              16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(3) != 0) begin
        roll = $urandom_range(9);
        write_reg(CFG_ILIM, roll == 0 ? 16'd0 : roll == 1 ? 16'd32767 :
                            roll < 7 ? 16'($urandom_range(0, 4096)) :
                            16'($urandom_range(0, 32767)));
      end
      if ($urandom_range(3) != 0) begin
        roll = $urandom_range(9);
        if (roll < 7) begin
          lo = $urandom_range(0, 40);
          hi = $urandom_range(60, 100);
        end else if (roll == 7) begin
          lo = 0;
          hi = 100;
        end else if (roll == 8) begin
          lo = $urandom_range(50, 100);
          hi = $urandom_range(0, 49);
        end else begin
          lo = $urandom_range(0, 100);
          hi = lo;
        end
        write_reg(CFG_OUT_MIN, lo[CFG_DATA_W-1:0]);
        write_reg(CFG_OUT_MAX, hi[CFG_DATA_W-1:0]);
      end
      if ($urandom_range(3) != 0) begin
        roll = $urandom_range(9);
        t = roll == 0 ? -880 : roll == 1 ? 2000 : int'($urandom_range(0, 2880)) - 880;
        write_reg(CFG_TARGET, t[CFG_DATA_W-1:0]);
      end
      if ($urandom_range(3) != 0) begin
        roll = $urandom_range(9);
        write_reg(CFG_MAX_WATTS, roll == 0 ? 16'd1 : roll == 1 ? 16'd16000 :
                                 16'($urandom_range(1, 16000)));
      end

      seg_items = $urandom_range(1100, 2300);
      repeat (seg_items) begin
        b = '0;
        roll = $urandom_range(99);
        b.action = roll < 86 ? ACT_TICK : roll < 92 ? ACT_SET_PCT :
                   roll < 98 ? ACT_SET_WATT : ACT_UNUSED;
        if (b.action == ACT_SET_WATT && $urandom_range(9) < 6)
          b.set_value = $urandom_range(0, int'(max_watts_r) + 200);
        else if (b.action == ACT_SET_PCT && $urandom_range(1) == 1)
          b.set_value = $urandom_range(0, 110);
        else
          b.set_value = $urandom_range(0, 65535);
        b.run_enable = $urandom_range(99) < 92;
        b.sensor_ok  = $urandom_range(99) < 88;
        // Keep most readings near the setpoint so the PI output lands inside its limits
        if ($urandom_range(9) < 7) t = int'(target_r) + int'($urandom_range(0, 192)) - 96;
        else t = int'($urandom_range(0, 2880)) - 880;
        if (t < -880) t = -880;
        if (t > 2000) t = 2000;
        b.temperature = t[TEMP_W-1:0];
        goal = $urandom_range(0, 16000);
        b.target_power_w = goal[TPWR_W-1:0];
        if ($urandom_range(9) < 6) begin
          spread = goal / 10 + 40;
          t = goal - spread + int'($urandom_range(0, 2 * spread));
          if (t < 0) t = 0;
        end else begin
          t = $urandom_range(0, 25000);
        end
        b.meter_power_w = t[METER_W-1:0];
        send_beat(b, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
